FILE: rtl/dtb_pkg.sv
// ----------------------------------------------------------------------------
// dtb_pkg
// Shared types, constants and helpers for the dual token bucket limiter.
// ----------------------------------------------------------------------------
package dtb_pkg;

    localparam int TS_W     = 48;
    localparam int SIZE_W   = 16;
    localparam int RATE_W   = 32;
    localparam int BURST_W  = 16;
    localparam int GAP_W    = 32;
    localparam int TOKEN_W  = 32;
    localparam int CREDIT_W = 44;
    localparam int FRAC_W   = 16;
    localparam int ADD_W    = RATE_W + GAP_W;
    localparam int BADD_W   = CREDIT_W + SIZE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [SIZE_W-1:0]   COMMAND_BYTES = 16'd4096;
    localparam logic [TOKEN_W-1:0]  ONE_TOKEN     = 32'h0001_0000;
    localparam logic [CREDIT_W-1:0] CREDIT_MAX    = {CREDIT_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REFILL_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP     = 2'd2;

    localparam logic [RATE_W-1:0]  RESET_REFILL_RATE = 32'd65;
    localparam logic [BURST_W-1:0] RESET_BURST_SIZE  = 16'd8;
    localparam logic [GAP_W-1:0]   RESET_MAX_GAP     = 32'd10000000;

    typedef struct packed {
        logic [RATE_W-1:0]   refill_rate;
        logic [BURST_W-1:0]  burst_size;
        logic [GAP_W-1:0]    max_gap;
        logic [CREDIT_W-1:0] byte_cap;
    } cfg_t;

    // Byte cap in Q28.16, saturated to the credit width.
    function automatic logic [CREDIT_W-1:0] byte_cap_of(input logic [BURST_W-1:0] burst);
        logic [BURST_W+SIZE_W-1:0]        prod;
        logic [BURST_W+SIZE_W+FRAC_W-1:0] cap;
        prod = (BURST_W+SIZE_W)'(burst) * (BURST_W+SIZE_W)'(COMMAND_BYTES);
        cap  = {prod, {FRAC_W{1'b0}}};
        if (cap > (BURST_W+SIZE_W+FRAC_W)'(CREDIT_MAX))
            return CREDIT_MAX;
        else
            return cap[CREDIT_W-1:0];
    endfunction

endpackage

FILE: rtl/dtb_cfg.sv
// ----------------------------------------------------------------------------
// dtb_cfg
// Configuration registers, with the byte cap worked out at write time.
// ----------------------------------------------------------------------------
module dtb_cfg
    import dtb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_REFILL_RATE: cfg_next.refill_rate = cfg_data[RATE_W-1:0];
                REG_BURST_SIZE:
                begin
                    cfg_next.burst_size = cfg_data[BURST_W-1:0];
                    cfg_next.byte_cap   = byte_cap_of(cfg_data[BURST_W-1:0]);
                end
                REG_MAX_GAP:     cfg_next.max_gap = cfg_data[GAP_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.refill_rate <= RESET_REFILL_RATE;
            cfg_reg.burst_size  <= RESET_BURST_SIZE;
            cfg_reg.max_gap     <= RESET_MAX_GAP;
            cfg_reg.byte_cap    <= byte_cap_of(RESET_BURST_SIZE);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/dtb_core.sv
// ----------------------------------------------------------------------------
// dtb_core
// Bucket state and the combinational refill, grant and debit logic.
// ----------------------------------------------------------------------------
module dtb_core
    import dtb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              step,
    input  logic [TS_W-1:0]   timestamp,
    input  logic [SIZE_W-1:0] request_size,
    output logic              grant
);

    logic                started_reg;
    logic [TS_W-1:0]     last_time_reg;
    logic [TOKEN_W-1:0]  tokens_reg;
    logic [CREDIT_W-1:0] credit_reg;

    logic                started_next;
    logic [TS_W-1:0]     last_time_next;
    logic [TOKEN_W-1:0]  tokens_next;
    logic [CREDIT_W-1:0] credit_next;

    logic                oversize;
    logic [TOKEN_W-1:0]  tcap;
    logic [TOKEN_W-1:0]  tokens_base;
    logic [CREDIT_W-1:0] credit_base;
    logic [TS_W-1:0]     last_base;
    logic                ts_ahead;
    logic [TS_W-1:0]     dt_raw;
    logic [GAP_W-1:0]    dt;
    logic [ADD_W-1:0]    add;
    logic [TOKEN_W:0]    tok_sum;
    logic [TOKEN_W-1:0]  tok_refill;
    logic                add_big;
    logic [BADD_W-1:0]   badd;
    logic [CREDIT_W:0]   cr_sum;
    logic [CREDIT_W-1:0] cr_refill;
    logic [TOKEN_W-1:0]  need;

    always_comb
    begin
        oversize = request_size > COMMAND_BYTES;
        tcap     = {cfg.burst_size, {FRAC_W{1'b0}}};

        // First beat fills both buckets and pins the time base
        tokens_base = started_reg ? tokens_reg    : tcap;
        credit_base = started_reg ? credit_reg    : cfg.byte_cap;
        last_base   = started_reg ? last_time_reg : timestamp;

        ts_ahead = timestamp > last_base;
        dt_raw   = timestamp - last_base;
        if (!ts_ahead)
            dt = '0;
        else if (dt_raw > TS_W'(cfg.max_gap))
            dt = cfg.max_gap;
        else
            dt = dt_raw[GAP_W-1:0];

        add = ADD_W'(dt) * ADD_W'(cfg.refill_rate);

        tok_sum = (TOKEN_W+1)'(tokens_base) + (TOKEN_W+1)'(add[TOKEN_W-1:0]);
        if (add >= ADD_W'(tcap))
            tok_refill = tcap;
        else if (tok_sum > (TOKEN_W+1)'(tcap))
            tok_refill = tcap;
        else
            tok_refill = tok_sum[TOKEN_W-1:0];

        // Scale to bytes; anything past the credit width already saturates
        add_big = |add[ADD_W-1:CREDIT_W];
        badd    = BADD_W'(add[CREDIT_W-1:0]) * BADD_W'(COMMAND_BYTES);
        cr_sum  = (CREDIT_W+1)'(credit_base) + (CREDIT_W+1)'(badd[CREDIT_W-1:0]);
        if (add_big || badd >= BADD_W'(cfg.byte_cap))
            cr_refill = cfg.byte_cap;
        else if (cr_sum > (CREDIT_W+1)'(cfg.byte_cap))
            cr_refill = cfg.byte_cap;
        else
            cr_refill = cr_sum[CREDIT_W-1:0];

        need  = {request_size, {FRAC_W{1'b0}}};
        grant = !oversize && (tok_refill >= ONE_TOKEN)
                && (cr_refill >= CREDIT_W'(need));

        started_next   = started_reg;
        last_time_next = last_time_reg;
        tokens_next    = tokens_reg;
        credit_next    = credit_reg;
        if (step && !oversize)
        begin
            started_next   = 1'b1;
            last_time_next = ts_ahead ? timestamp : last_base;
            tokens_next    = grant ? tok_refill - ONE_TOKEN : tok_refill;
            credit_next    = grant ? cr_refill - CREDIT_W'(need) : cr_refill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            last_time_reg <= '0;
            tokens_reg    <= '0;
            credit_reg    <= '0;
        end
        else
        begin
            started_reg   <= started_next;
            last_time_reg <= last_time_next;
            tokens_reg    <= tokens_next;
            credit_reg    <= credit_next;
        end
    end

endmodule

FILE: rtl/dual_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// dual_token_bucket_limiter
// Request/byte rate limiter: input register, bucket update, result register.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------
//  in       | in        | in_valid / in_ready  | timestamp, request_size
//  out      | out       | out_valid / out_ready| granted
//  cfg      | in        | cfg_write            | cfg_index, cfg_data
//
//  One request per cycle while the out channel is not stalled; a request
//  passes the input register and the result register before out_valid rises.
//  The rate is set by the bucket update loop (multiply, saturating
//  adds, compare) that each request must close before the next one reads it.
//  Reset restores the register defaults; the first request fills the buckets.
//  A stalled out channel holds the result; one more beat waits in the input
//  register, then in_ready drops.
// ----------------------------------------------------------------------------
module dual_token_bucket_limiter
    import dtb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TS_W-1:0]       timestamp,
    input  logic [SIZE_W-1:0]     request_size,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  granted,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    logic              s1_valid_reg;
    logic [TS_W-1:0]   s1_ts_reg;
    logic [SIZE_W-1:0] s1_size_reg;
    logic              out_valid_reg;
    logic              granted_reg;

    logic              s1_valid_next;
    logic              out_valid_next;
    logic              advance;
    logic              step;
    logic              grant;

    dtb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dtb_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .step         (step),
        .timestamp    (s1_ts_reg),
        .request_size (s1_size_reg),
        .grant        (grant)
    );

    always_comb
    begin
        advance        = !out_valid_reg || out_ready;
        step           = s1_valid_reg && advance;
        in_ready       = !s1_valid_reg || advance;
        s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_ts_reg   <= timestamp;
            s1_size_reg <= request_size;
        end
        if (step)
        begin
            granted_reg <= grant;
        end
    end

    assign out_valid = out_valid_reg;
    assign granted   = granted_reg;

endmodule

FILE: rtl/dtb_checker.sv
// ----------------------------------------------------------------------------
// dtb_checker
// Port-level checks on the limiter, bound to the top level.
// ----------------------------------------------------------------------------
module dtb_checker
    import dtb_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [SIZE_W-1:0] request_size,
    input logic              out_valid,
    input logic              out_ready,
    input logic              granted
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(granted))
        else $error("result changed while stalled");

    // An empty output side never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // A beat reaches the output when the sink is ready while it waits in the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("result missing after two cycles");

    // Oversized requests are never granted
    a_oversize_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (request_size > COMMAND_BYTES)) ##1 out_ready
        |=> !granted)
        else $error("oversized request granted");

endmodule

bind dual_token_bucket_limiter dtb_checker u_dtb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .request_size (request_size),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .granted      (granted)
);
